// ===== rtl/tct_pkg.sv =====
// Shared types, codes and default sizes of the touch contact tracker.
`default_nettype none

package tct_pkg;

   // Fixed field widths.
   localparam int ID_BITS    = 32;
   localparam int KIND_BITS  = 2;
   localparam int EVENT_BITS = 2;

   // Default sizes, handed to the top level's parameters.
   localparam int DEF_SLOTS       = 10;
   localparam int DEF_COORD_BITS  = 16;
   localparam int DEF_WINDOW_BITS = 16;

   // Touch event kinds on the request side.
   localparam logic [KIND_BITS-1:0] KIND_DOWN   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_UP     = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_MOTION = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_CANCEL = 2'd3;

   // Pointer event codes on the response side.
   localparam logic [EVENT_BITS-1:0] EV_DOWN   = 2'd0;
   localparam logic [EVENT_BITS-1:0] EV_UPDATE = 2'd1;
   localparam logic [EVENT_BITS-1:0] EV_UP     = 2'd2;

   // Write strobes into the slot file: a whole entry, or the position only.
   typedef struct packed {
      logic full;
      logic pos;
   } tct_wr_type;

endpackage

`default_nettype wire

// ===== rtl/tct_clamp.sv =====
// Shared clamp unit: limits one coordinate into a half-open range.
`default_nettype none

module tct_clamp
   import tct_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic signed [COORD_BITS-1:0] pos,
   input  wire logic signed [COORD_BITS-1:0] lo,
   input  wire logic signed [COORD_BITS-1:0] hi,
   output logic signed [COORD_BITS-1:0]      res
);

   localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic signed [COORD_BITS-1:0] hi_m1;

   // The far edge is exclusive; at the most negative value it saturates.
   assign hi_m1 = (hi == CMIN) ? CMIN : (hi - $signed(COORD_BITS'(1)));

   always_comb begin
      if (pos >= hi) begin
         res = hi_m1;
      end else if (pos < lo) begin
         res = lo;
      end else begin
         res = pos;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tct_slot_file.sv =====
// Slot file holding the id, window and position of every tracked contact.
`default_nettype none

module tct_slot_file
   import tct_pkg::*;
#(
   parameter int SLOTS       = DEF_SLOTS,
   parameter int COORD_BITS  = DEF_COORD_BITS,
   parameter int WINDOW_BITS = DEF_WINDOW_BITS,
   localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire logic                          clock,
   input  wire tct_wr_type                    wr,
   input  wire logic [IDX_W-1:0]              wr_addr,
   input  wire logic [ID_BITS-1:0]            wr_id,
   input  wire logic [WINDOW_BITS-1:0]        wr_window,
   input  wire logic signed [COORD_BITS-1:0]  wr_x,
   input  wire logic signed [COORD_BITS-1:0]  wr_y,
   input  wire logic [IDX_W-1:0]              rd_addr,
   output logic [ID_BITS-1:0]                 rd_id,
   output logic [WINDOW_BITS-1:0]             rd_window,
   output logic signed [COORD_BITS-1:0]       rd_x,
   output logic signed [COORD_BITS-1:0]       rd_y
);

   logic [ID_BITS-1:0]           id_ff     [SLOTS];
   logic [WINDOW_BITS-1:0]       window_ff [SLOTS];
   logic signed [COORD_BITS-1:0] x_ff      [SLOTS];
   logic signed [COORD_BITS-1:0] y_ff      [SLOTS];

   // Entries are only read while their slot is marked active, so no reset.
   always_ff @(posedge clock) begin
      if (wr.full) begin
         id_ff[wr_addr]     <= wr_id;
         window_ff[wr_addr] <= wr_window;
      end
      if (wr.full || wr.pos) begin
         x_ff[wr_addr] <= wr_x;
         y_ff[wr_addr] <= wr_y;
      end
   end

   assign rd_id     = id_ff[rd_addr];
   assign rd_window = window_ff[rd_addr];
   assign rd_x      = x_ff[rd_addr];
   assign rd_y      = y_ff[rd_addr];

endmodule

`default_nettype wire

// ===== rtl/touch_contact_tracker.sv =====
// Top level of the touch contact tracker: sequencer, active marks and result register.
`default_nettype none

// The block follows up to SLOTS touch contacts, each bound to the window it
// went down on. One request word is one touch event (down, up, motion or
// cancel) carrying screen coordinates and the target window's rectangle; it
// yields zero or more response words, the final one of a run marked by last.
// Both channels use valid and ready. req_ready is high only while the
// sequencer is idle; once a word is taken the block clamps the x axis and
// then the y axis through a single shared clamp unit, then visits the slot
// file one slot per cycle (a cancel scan pauses on an active slot while the
// response register is full); a down, up or motion word loads its response
// after the scan. A cancel emits one up word per active slot in slot order
// as the scan passes it.
// The response register parts the two sides: the next request word may be
// taken while the last response still waits. When the receiver stalls, the
// sequencer holds at the point where it would load a new response, and the
// cancel scan stops on the slot concerned until the register frees.
// A synchronous reset clears every active mark and empties the response
// register; the slot contents need no clearing pass.

module touch_contact_tracker
   import tct_pkg::*;
#(
   parameter int SLOTS       = DEF_SLOTS,
   parameter int COORD_BITS  = DEF_COORD_BITS,
   parameter int WINDOW_BITS = DEF_WINDOW_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [KIND_BITS-1:0]          req_kind,
   input  wire logic signed [ID_BITS-1:0]     req_contact_id,
   input  wire logic [WINDOW_BITS-1:0]        req_window,
   input  wire logic                          req_target_ok,
   input  wire logic signed [COORD_BITS-1:0]  req_pos_x,
   input  wire logic signed [COORD_BITS-1:0]  req_pos_y,
   input  wire logic signed [COORD_BITS-1:0]  req_rect_left,
   input  wire logic signed [COORD_BITS-1:0]  req_rect_top,
   input  wire logic signed [COORD_BITS-1:0]  req_rect_right,
   input  wire logic signed [COORD_BITS-1:0]  req_rect_bottom,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [EVENT_BITS-1:0]              rsp_event_res,
   output logic signed [ID_BITS-1:0]          rsp_out_id,
   output logic [WINDOW_BITS-1:0]             rsp_out_window,
   output logic signed [COORD_BITS-1:0]       rsp_out_x,
   output logic signed [COORD_BITS-1:0]       rsp_out_y,
   output logic                               rsp_is_new,
   output logic                               rsp_last
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CLAMP_X = 3'd1;
   localparam logic [2:0] S_CLAMP_Y = 3'd2;
   localparam logic [2:0] S_SCAN    = 3'd3;
   localparam logic [2:0] S_FINISH  = 3'd4;

   // Sequencer and control state.
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SLOTS-1:0] active_ff, active_in;
   logic             match_found_ff, match_found_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   // Captured request word.
   logic [KIND_BITS-1:0]         kind_ff, kind_in;
   logic [ID_BITS-1:0]           id_ff, id_in;
   logic [WINDOW_BITS-1:0]       win_ff, win_in;
   logic                         ok_ff, ok_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [COORD_BITS-1:0] rl_ff, rl_in, rt_ff, rt_in;
   logic signed [COORD_BITS-1:0] rr_ff, rr_in, rb_ff, rb_in;

   // Clamped position and the entry captured at the matching slot.
   logic signed [COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [WINDOW_BITS-1:0]       cap_win_ff, cap_win_in;
   logic signed [COORD_BITS-1:0] cap_x_ff, cap_x_in, cap_y_ff, cap_y_in;

   // Response register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [EVENT_BITS-1:0]        rsp_event_ff, rsp_event_in;
   logic [ID_BITS-1:0]           rsp_id_ff, rsp_id_in;
   logic [WINDOW_BITS-1:0]       rsp_win_ff, rsp_win_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                         rsp_new_ff, rsp_new_in;
   logic                         rsp_last_ff, rsp_last_in;

   // Shared clamp unit and slot file connections.
   logic                         clamp_y_sel;
   logic signed [COORD_BITS-1:0] clamp_pos, clamp_lo, clamp_hi, clamp_res;
   tct_wr_type                   wr;
   logic [IDX_W-1:0]             wr_addr;
   logic [ID_BITS-1:0]           rd_id;
   logic [WINDOW_BITS-1:0]       rd_window;
   logic signed [COORD_BITS-1:0] rd_x, rd_y;

   logic             out_free;
   logic             hit;
   logic             take_free;
   logic [IDX_W-1:0] down_target;
   logic             down_go;
   logic             one_left;
   logic             load;
   logic             scan_step;

   // The clamp unit serves the x axis in state S_CLAMP_X and the y axis in S_CLAMP_Y.
   assign clamp_y_sel = (state_ff == S_CLAMP_Y);
   assign clamp_pos   = clamp_y_sel ? py_ff : px_ff;
   assign clamp_lo    = clamp_y_sel ? rt_ff : rl_ff;
   assign clamp_hi    = clamp_y_sel ? rb_ff : rr_ff;

   tct_clamp #(
      .COORD_BITS (COORD_BITS)
   ) u_clamp (
      .pos (clamp_pos),
      .lo  (clamp_lo),
      .hi  (clamp_hi),
      .res (clamp_res)
   );

   tct_slot_file #(
      .SLOTS       (SLOTS),
      .COORD_BITS  (COORD_BITS),
      .WINDOW_BITS (WINDOW_BITS)
   ) u_slot_file (
      .clock     (clock),
      .wr        (wr),
      .wr_addr   (wr_addr),
      .wr_id     (id_ff),
      .wr_window (win_ff),
      .wr_x      (cx_ff),
      .wr_y      (cy_ff),
      .rd_addr   (idx_ff),
      .rd_id     (rd_id),
      .rd_window (rd_window),
      .rd_x      (rd_x),
      .rd_y      (rd_y)
   );

   // The response register may be reloaded when empty or being emptied now.
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign hit = active_ff[idx_ff] && (rd_id == id_ff);

   // A down word takes the lowest slot that is free once a stale contact with
   // the same id has been dropped: the first free slot or that stale slot.
   assign take_free   = free_found_ff && (!match_found_ff || (free_idx_ff < match_idx_ff));
   assign down_target = take_free ? free_idx_ff : match_idx_ff;
   assign down_go     = ok_ff && (take_free || match_found_ff);

   // During a cancel the slots below the scan are already freed, so the
   // current slot is the final one when it is the only active mark left.
   assign one_left = ((active_ff & (active_ff - SLOTS'(1))) == '0);

   // A cancel scan waits on an active slot until the response register frees.
   assign scan_step = !((kind_ff == KIND_CANCEL) && active_ff[idx_ff] && !out_free);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      active_in      = active_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      kind_in        = kind_ff;
      id_in          = id_ff;
      win_in         = win_ff;
      ok_in          = ok_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      rl_in          = rl_ff;
      rt_in          = rt_ff;
      rr_in          = rr_ff;
      rb_in          = rb_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      cap_win_in     = cap_win_ff;
      cap_x_in       = cap_x_ff;
      cap_y_in       = cap_y_ff;
      rsp_event_in   = rsp_event_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_win_in     = rsp_win_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_new_in     = rsp_new_ff;
      rsp_last_in    = rsp_last_ff;
      wr             = '0;
      wr_addr        = match_idx_ff;
      load           = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in        = req_kind;
               id_in          = req_contact_id;
               win_in         = req_window;
               ok_in          = req_target_ok;
               px_in          = req_pos_x;
               py_in          = req_pos_y;
               rl_in          = req_rect_left;
               rt_in          = req_rect_top;
               rr_in          = req_rect_right;
               rb_in          = req_rect_bottom;
               idx_in         = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               state_in       = S_CLAMP_X;
            end
         end
         S_CLAMP_X: begin
            cx_in    = clamp_res;
            state_in = S_CLAMP_Y;
         end
         S_CLAMP_Y: begin
            cy_in    = clamp_res;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (kind_ff == KIND_CANCEL) begin
               if (active_ff[idx_ff] && out_free) begin
                  load              = 1'b1;
                  rsp_event_in      = EV_UP;
                  rsp_id_in         = rd_id;
                  rsp_win_in        = rd_window;
                  rsp_x_in          = rd_x;
                  rsp_y_in          = rd_y;
                  rsp_new_in        = 1'b0;
                  rsp_last_in       = one_left;
                  active_in[idx_ff] = 1'b0;
               end
            end else begin
               if (hit && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_idx_in   = idx_ff;
                  cap_win_in     = rd_window;
                  cap_x_in       = rd_x;
                  cap_y_in       = rd_y;
               end
               if (!active_ff[idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
            end
            if (scan_step) begin
               if (idx_ff == LAST_IDX) begin
                  state_in = (kind_ff == KIND_CANCEL) ? S_IDLE : S_FINISH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_FINISH: begin
            case (kind_ff)
               KIND_DOWN: begin
                  if (!down_go) begin
                     state_in = S_IDLE;
                  end else if (out_free) begin
                     if (match_found_ff) begin
                        active_in[match_idx_ff] = 1'b0;
                     end
                     active_in[down_target] = 1'b1;
                     wr.full      = 1'b1;
                     wr_addr      = down_target;
                     load         = 1'b1;
                     rsp_event_in = EV_DOWN;
                     rsp_id_in    = id_ff;
                     rsp_win_in   = win_ff;
                     rsp_x_in     = cx_ff;
                     rsp_y_in     = cy_ff;
                     rsp_new_in   = 1'b1;
                     rsp_last_in  = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               KIND_UP: begin
                  if (!match_found_ff) begin
                     state_in = S_IDLE;
                  end else if (out_free) begin
                     active_in[match_idx_ff] = 1'b0;
                     load         = 1'b1;
                     rsp_event_in = EV_UP;
                     rsp_id_in    = id_ff;
                     rsp_win_in   = cap_win_ff;
                     rsp_x_in     = cap_x_ff;
                     rsp_y_in     = cap_y_ff;
                     rsp_new_in   = 1'b0;
                     rsp_last_in  = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               KIND_MOTION: begin
                  if (!(match_found_ff && ok_ff)) begin
                     state_in = S_IDLE;
                  end else if (out_free) begin
                     wr.pos       = 1'b1;
                     wr_addr      = match_idx_ff;
                     load         = 1'b1;
                     rsp_event_in = EV_UPDATE;
                     rsp_id_in    = id_ff;
                     rsp_win_in   = cap_win_ff;
                     rsp_x_in     = cx_ff;
                     rsp_y_in     = cy_ff;
                     rsp_new_in   = 1'b0;
                     rsp_last_in  = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      kind_ff        <= kind_in;
      id_ff          <= id_in;
      win_ff         <= win_in;
      ok_ff          <= ok_in;
      px_ff          <= px_in;
      py_ff          <= py_in;
      rl_ff          <= rl_in;
      rt_ff          <= rt_in;
      rr_ff          <= rr_in;
      rb_ff          <= rb_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      cap_win_ff     <= cap_win_in;
      cap_x_ff       <= cap_x_in;
      cap_y_ff       <= cap_y_in;
      rsp_event_ff   <= rsp_event_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_win_ff     <= rsp_win_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_new_ff     <= rsp_new_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_res  = rsp_event_ff;
   assign rsp_out_id     = rsp_id_ff;
   assign rsp_out_window = rsp_win_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_is_new     = rsp_new_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/tct_checker.sv =====
// Port-level checks of the touch contact tracker and their binding to it.
`default_nettype none

module tct_checker
   import tct_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [EVENT_BITS-1:0] rsp_event_res,
   input wire logic                  rsp_is_new,
   input wire logic                  rsp_last
);

   // A taken request word leaves the sequencer busy in the following cycle.
   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while the previous word was still in work");

   // A waiting response word is not withdrawn.
   rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response word dropped before it was taken");

   // Only a down event marks a new contact.
   new_only_on_down: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_new) |-> (rsp_event_res == EV_DOWN))
      else $error("new contact flag on an event other than down");

   // Down and update words are single results and so close their run.
   single_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_res == EV_DOWN || rsp_event_res == EV_UPDATE)) |-> rsp_last)
      else $error("down or update word not marked as the last of its run");

endmodule

bind touch_contact_tracker tct_checker u_tct_checker (.*);

`default_nettype wire
